// ----- rtl/ppm_pkg.sv -----
// shared types and constants for the phrase proximity matcher
// no dependencies; imported by every module of the block
package ppm_pkg;

  // fixed field widths
  localparam int DOC_BITS       = 24;
  localparam int PROX_BITS      = 24;
  localparam int TC_BITS        = 4;
  localparam int SLOT_BITS      = 3;
  localparam int OUT_USER_BITS  = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 24;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROXIMITY  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TERM_COUNT = 1'b1;

  localparam logic [TC_BITS-1:0] TERM_COUNT_RESET = 4'd2;

  // top level sequencing
  typedef enum logic [1:0] {
    T_LOAD,
    T_WALK,
    T_EMIT
  } top_state_t;

  // match walk sequencing
  typedef enum logic [1:0] {
    W_IDLE,
    W_START,
    W_START_WAIT,
    W_SCAN
  } walk_state_t;

  // walk result reported back to the top level
  typedef struct packed {
    logic done;
    logic found;
  } walk_status_t;

endpackage

// ----- rtl/ppm_pos_mem.sv -----
// position store: one synchronous memory, one write and one read port
// read data is registered; uses ppm_pkg only for style
module ppm_pos_mem #(
  parameter int AW = 11,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  import ppm_pkg::*;

  logic [DW-1:0] mem [(2**AW)];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ppm_walk.sv -----
// ordered chain walk over the stored positions of one document
// reads the position store through ppm_pos_mem; types from ppm_pkg
module ppm_walk #(
  parameter int MAX_TERMS     = 8,
  parameter int MAX_POSITIONS = 256,
  parameter int POSITION_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] n_m1,
  input  logic [ppm_pkg::PROX_BITS-1:0]    proximity,
  output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] fill_term,
  input  logic [$clog2(MAX_POSITIONS):0]   fill_cnt,
  output logic                             rd_en,
  output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1) + $clog2(MAX_POSITIONS)-1:0]
                                           rd_addr,
  input  logic [POSITION_BITS-1:0]         rd_data,
  output ppm_pkg::walk_status_t            status
);
  import ppm_pkg::*;

  localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PW = $clog2(MAX_POSITIONS);
  localparam int LW = ((POSITION_BITS > PROX_BITS) ? POSITION_BITS : PROX_BITS) + 1;
  localparam int BW = LW + 1;

  walk_state_t        state, state_next;
  logic [PW:0]        s_idx, s_idx_next;
  logic [PW:0]        i_idx, i_idx_next;
  logic [TW-1:0]      t_idx, t_idx_next;
  logic               pend, pend_next;
  logic [POSITION_BITS-1:0] prev, prev_next;
  logic [LW-1:0]      limit, limit_next;
  logic [BW-1:0]      bound, bound_next;
  logic               hit;

  assign hit = pend && (rd_data > prev);

  // state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
    s_idx <= s_idx_next;
    i_idx <= i_idx_next;
    t_idx <= t_idx_next;
    prev  <= prev_next;
    limit <= limit_next;
    bound <= bound_next;
  end

  // next state, memory requests and result
  always_comb begin
    state_next = state;
    s_idx_next = s_idx;
    i_idx_next = i_idx;
    t_idx_next = t_idx;
    pend_next  = pend;
    prev_next  = prev;
    limit_next = limit;
    bound_next = bound;
    rd_en      = 1'b0;
    rd_addr    = '0;
    fill_term  = '0;
    status     = '0;
    unique case (state)
      W_IDLE: begin
        pend_next = 1'b0;
        if (start) begin
          s_idx_next = '0;
          // allowed span beyond the start: proximity plus exact adjacency
          limit_next = LW'(proximity) + LW'(n_m1);
          state_next = W_START;
        end
      end
      W_START: begin
        fill_term = '0;
        if (s_idx == fill_cnt) begin
          status.done = 1'b1;
          state_next  = W_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = {TW'(0), s_idx[PW-1:0]};
          state_next = W_START_WAIT;
        end
      end
      W_START_WAIT: begin
        prev_next  = rd_data;
        bound_next = BW'(rd_data) + BW'(limit);
        if (n_m1 == TW'(0)) begin
          // single term: any start matches
          status.done  = 1'b1;
          status.found = 1'b1;
          state_next   = W_IDLE;
        end else begin
          t_idx_next = TW'(1);
          i_idx_next = '0;
          pend_next  = 1'b0;
          state_next = W_SCAN;
        end
      end
      W_SCAN: begin
        fill_term = t_idx;
        if (hit) begin
          prev_next = rd_data;
          pend_next = 1'b0;
          if (t_idx == n_m1) begin
            if (BW'(rd_data) <= bound) begin
              status.done  = 1'b1;
              status.found = 1'b1;
              state_next   = W_IDLE;
            end else begin
              s_idx_next = s_idx + 1'b1;
              state_next = W_START;
            end
          end else begin
            t_idx_next = t_idx + 1'b1;
            i_idx_next = '0;
          end
        end else if (i_idx != fill_cnt) begin
          // stream the next entry of this term
          rd_en      = 1'b1;
          rd_addr    = {t_idx, i_idx[PW-1:0]};
          i_idx_next = i_idx + 1'b1;
          pend_next  = 1'b1;
        end else begin
          // term exhausted: chain fails, try the next start
          pend_next  = 1'b0;
          s_idx_next = s_idx + 1'b1;
          state_next = W_START;
        end
      end
      default: begin
        state_next = W_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/phrase_proximity_matcher.sv -----
// phrase proximity matcher top level: load path, fill counts, config, result
// instantiates ppm_pos_mem and ppm_walk; types and constants from ppm_pkg
//
// usage: positions of one document stream in on the s_axis channel, one item
// per cycle: tdata carries doc_ident and token_position, tuser the term slot,
// tlast marks the closing item. each accepted item with an in-range slot is
// written to the position store unless its term is full. the closing item
// starts the match walk; the block takes no items until the result has been
// moved to the output register. the walk reads each term 0 start position,
// then for each later term it reaches streams stored entries until one lies
// after the previous match; its length is set by the single read port of the
// position store. one result per document leaves on m_axis: tdata is the
// document id, tuser holds phrase_found and capacity_overflow. a result waits
// in the output register while the receiver stalls; the next document may
// load meanwhile. the cfg channel (always ready) writes proximity and
// term_count; the user must write them only while idle, the block does not
// enforce it. reset clears fill counts, overflow flag, config registers,
// state and handshakes; the position store needs no clearing since only
// filled entries are read.
module phrase_proximity_matcher #(
  parameter int MAX_TERMS     = 8,
  parameter int MAX_POSITIONS = 256,
  parameter int POSITION_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // doc_ident [23:0], token_position above it, zero fill to whole bytes
  input  logic [((ppm_pkg::DOC_BITS + POSITION_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // term_slot
  input  logic [ppm_pkg::SLOT_BITS-1:0]        s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // result items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_doc
  output logic [ppm_pkg::DOC_BITS-1:0]         m_axis_tdata,
  // phrase_found [0], capacity_overflow [1]
  output logic [ppm_pkg::OUT_USER_BITS-1:0]    m_axis_tuser,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ppm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import ppm_pkg::*;

  localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PW = $clog2(MAX_POSITIONS);
  localparam int AW = TW + PW;

  top_state_t             state, state_next;
  logic [PROX_BITS-1:0]   proximity;
  logic [TC_BITS-1:0]     term_count;
  logic [PW:0]            fill [MAX_TERMS];
  logic                   overflow_seen;
  logic [DOC_BITS-1:0]    doc_hold;
  logic                   found_hold;

  logic                   in_accept;
  logic [DOC_BITS-1:0]    in_doc;
  logic [POSITION_BITS-1:0] in_pos;
  logic                   slot_ok;
  logic [TW-1:0]          slot_idx;
  logic [TW-1:0]          fill_sel;
  logic [PW:0]            fill_cnt;
  logic                   term_full;
  logic                   wr_en;
  logic                   out_free;
  logic                   emit;

  logic [TW-1:0]          n_m1;
  logic [TW-1:0]          walk_term;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [POSITION_BITS-1:0] rd_data;
  walk_status_t           walk_status;

  // input unpacking
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_doc    = s_axis_tdata[DOC_BITS-1:0];
  assign in_pos    = s_axis_tdata[DOC_BITS +: POSITION_BITS];
  assign slot_ok   = 32'(s_axis_tuser) < MAX_TERMS;
  assign slot_idx  = TW'(s_axis_tuser);

  // fill count lookup: load slot while loading, walk term otherwise
  assign fill_sel  = (state == T_LOAD) ? slot_idx : walk_term;
  assign fill_cnt  = fill[fill_sel];
  assign term_full = fill_cnt == (PW + 1)'(MAX_POSITIONS);
  assign wr_en     = in_accept && slot_ok && !term_full;

  // effective term count, clamped to 1 .. MAX_TERMS, minus one
  always_comb begin
    if (term_count == '0) begin
      n_m1 = '0;
    end else if (32'(term_count) > MAX_TERMS) begin
      n_m1 = TW'(MAX_TERMS - 1);
    end else begin
      n_m1 = TW'(term_count - 1'b1);
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      proximity  <= '0;
      term_count <= TERM_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROXIMITY:  proximity  <= cfg_data[PROX_BITS-1:0];
        REG_TERM_COUNT: term_count <= cfg_data[TC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencing
  assign s_axis_tready = state == T_LOAD;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state == T_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_LOAD: begin
        if (in_accept && s_axis_tlast) begin
          state_next = T_WALK;
        end
      end
      T_WALK: begin
        if (walk_status.done) begin
          state_next = T_EMIT;
        end
      end
      T_EMIT: begin
        if (out_free) begin
          state_next = T_LOAD;
        end
      end
      default: begin
        state_next = T_LOAD;
      end
    endcase
  end

  // fill counts and overflow flag, cleared once the result is emitted
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      for (int t = 0; t < MAX_TERMS; t++) begin
        fill[t] <= '0;
      end
      overflow_seen <= 1'b0;
    end else if (in_accept && slot_ok) begin
      if (term_full) begin
        overflow_seen <= 1'b1;
      end else begin
        fill[slot_idx] <= fill_cnt + 1'b1;
      end
    end
  end

  // hold document id and walk outcome until emitted
  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tlast) begin
      doc_hold <= in_doc;
    end
    if (walk_status.done) begin
      found_hold <= walk_status.found;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit) begin
      m_axis_tdata <= doc_hold;
      m_axis_tuser <= {overflow_seen, found_hold};
    end
  end

  ppm_pos_mem #(
    .AW (AW),
    .DW (POSITION_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({slot_idx, fill_cnt[PW-1:0]}),
    .wr_data (in_pos),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppm_walk #(
    .MAX_TERMS     (MAX_TERMS),
    .MAX_POSITIONS (MAX_POSITIONS),
    .POSITION_BITS (POSITION_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept && s_axis_tlast),
    .n_m1      (n_m1),
    .proximity (proximity),
    .fill_term (walk_term),
    .fill_cnt  (fill_cnt),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .status    (walk_status)
  );

endmodule
